// ----- hdl/assert_macros.svh -----
// assertion helpers, sampled on the rising clock edge, off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PFE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define PFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/pfe_pkg.sv -----
package pfe_pkg;

    localparam int FUNC_W    = 3;
    localparam int FNUM_W    = 29;
    localparam int VALUE_W   = 64;
    localparam int BYTE_W    = 8;
    localparam int GROUP_W   = 7;
    localparam int WT_W      = 3;
    localparam int COUNT_W   = 4;

    localparam logic [FUNC_W-1:0] FN_VARINT  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ZIGZAG  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FIXED32 = 3'd2;
    localparam logic [FUNC_W-1:0] FN_FIXED64 = 3'd3;
    localparam logic [FUNC_W-1:0] FN_LENHDR  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_PAYLOAD = 3'd5;

    localparam logic [WT_W-1:0] WT_VARINT  = 3'd0;
    localparam logic [WT_W-1:0] WT_FIXED64 = 3'd1;
    localparam logic [WT_W-1:0] WT_LENGTH  = 3'd2;
    localparam logic [WT_W-1:0] WT_FIXED32 = 3'd5;

    localparam logic [COUNT_W-1:0] CNT_ONE     = 4'd1;
    localparam logic [COUNT_W-1:0] CNT_FIXED32 = 4'd4;
    localparam logic [COUNT_W-1:0] CNT_FIXED64 = 4'd8;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [FNUM_W-1:0]  field_id;
        logic [VALUE_W-1:0] value_bits;
    } t_req;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_KEY,
        S_VAL
    } t_state;

    typedef enum logic {
        SM_VARINT,
        SM_FIXED
    } t_shift_mode;

    typedef struct packed {
        logic               load;
        logic               step;
        t_shift_mode        mode;
        logic [COUNT_W-1:0] count;
    } t_shift_ctl;

endpackage

// ----- hdl/pfe_shifter.sv -----
module pfe_shifter
    import pfe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_shift_ctl            i_ctl,
    input  logic [VALUE_W-1:0]    i_data,
    output logic [BYTE_W-1:0]     o_byte,
    output logic                  o_final
);

    logic [VALUE_W-1:0] r_data, n_data;
    t_shift_mode        r_mode, n_mode;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               rest_nz;

    // more groups follow while anything above the low group is set
    assign rest_nz = |r_data[VALUE_W-1:GROUP_W];

    always_comb begin
        if (r_mode == SM_VARINT) begin
            o_byte  = {rest_nz, r_data[GROUP_W-1:0]};
            o_final = !rest_nz;
        end else begin
            o_byte  = r_data[BYTE_W-1:0];
            o_final = (r_count == CNT_ONE);
        end
    end

    always_comb begin
        n_data  = r_data;
        n_mode  = r_mode;
        n_count = r_count;
        if (i_ctl.load) begin
            n_data  = i_data;
            n_mode  = i_ctl.mode;
            n_count = i_ctl.count;
        end else if (i_ctl.step) begin
            if (r_mode == SM_VARINT) begin
                n_data = r_data >> GROUP_W;
            end else begin
                n_data  = r_data >> BYTE_W;
                n_count = r_count - CNT_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_mode  <= SM_VARINT;
            r_count <= '0;
        end else begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

endmodule

// ----- hdl/protobuf_field_encoder_core.sv -----
// a taken request loads the shift register; bytes then move into o_rsp at
// one wire byte per cycle from a 7/8-bit shift register while o_rsp is empty
// or drained; a request of 1 to 15 bytes holds o_ready low until all are out
// unknown function codes are taken and produce nothing
// reset: synchronous active-low i_rst_n, clears the sequencer and output valid
module protobuf_field_encoder_core
    import pfe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);

`include "assert_macros.svh"

    t_state             r_state, n_state;
    logic [VALUE_W-1:0] r_value, n_value;
    t_shift_mode        r_val_mode, n_val_mode;
    logic [COUNT_W-1:0] r_val_count, n_val_count;
    logic               r_out_valid, n_out_valid;
    t_rsp               r_out, n_out;

    t_shift_ctl         shift_ctl;
    logic [VALUE_W-1:0] shift_data;
    logic [BYTE_W-1:0]  shift_byte;
    logic               shift_final;
    logic               in_fire;
    logic               emit;
    logic               func_known;
    logic [WT_W-1:0]    wire_type;
    logic [VALUE_W-1:0] key_word;
    logic [VALUE_W-1:0] zz_value;

    pfe_shifter u_shifter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (shift_ctl),
        .i_data  (shift_data),
        .o_byte  (shift_byte),
        .o_final (shift_final)
    );

    assign in_fire    = i_valid && o_ready;
    assign func_known = (i_req.func inside {FN_VARINT, FN_ZIGZAG, FN_FIXED32,
                                            FN_FIXED64, FN_LENHDR, FN_PAYLOAD});
    // a byte moves into the output register when it is empty or being drained
    assign emit       = (r_state != S_IDLE) && (!r_out_valid || i_ready);
    assign zz_value   = {i_req.value_bits[VALUE_W-2:0], 1'b0} ^
                        {VALUE_W{i_req.value_bits[VALUE_W-1]}};

    always_comb begin
        case (i_req.func)
            FN_FIXED32: wire_type = WT_FIXED32;
            FN_FIXED64: wire_type = WT_FIXED64;
            FN_LENHDR:  wire_type = WT_LENGTH;
            default:    wire_type = WT_VARINT;
        endcase
        key_word = {{(VALUE_W-FNUM_W-WT_W){1'b0}}, i_req.field_id, wire_type};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && func_known) begin
                    n_state = (i_req.func == FN_PAYLOAD) ? S_VAL : S_KEY;
                end
            end
            S_KEY: begin
                if (emit && shift_final) begin
                    n_state = S_VAL;
                end
            end
            S_VAL: begin
                if (emit && shift_final) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        o_ready         = 1'b0;
        shift_ctl.load  = 1'b0;
        shift_ctl.step  = 1'b0;
        shift_ctl.mode  = SM_VARINT;
        shift_ctl.count = CNT_ONE;
        shift_data      = key_word;
        n_value         = r_value;
        n_val_mode      = r_val_mode;
        n_val_count     = r_val_count;
        n_out_valid     = r_out_valid && !i_ready;
        n_out           = r_out;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (in_fire) begin
                    n_value     = (i_req.func == FN_ZIGZAG) ? zz_value : i_req.value_bits;
                    n_val_mode  = SM_VARINT;
                    n_val_count = CNT_ONE;
                    case (i_req.func)
                        FN_FIXED32: begin
                            n_val_mode  = SM_FIXED;
                            n_val_count = CNT_FIXED32;
                        end
                        FN_FIXED64: begin
                            n_val_mode  = SM_FIXED;
                            n_val_count = CNT_FIXED64;
                        end
                        default: ;
                    endcase
                    if (i_req.func == FN_PAYLOAD) begin
                        // the payload byte goes straight into the value phase
                        shift_ctl.load  = 1'b1;
                        shift_ctl.mode  = SM_FIXED;
                        shift_ctl.count = CNT_ONE;
                        shift_data      = i_req.value_bits;
                    end else if (func_known) begin
                        shift_ctl.load = 1'b1;
                    end
                end
            end
            S_KEY: begin
                if (emit) begin
                    n_out_valid  = 1'b1;
                    n_out.out_byte = shift_byte;
                    n_out.last   = 1'b0;
                    if (shift_final) begin
                        shift_ctl.load  = 1'b1;
                        shift_ctl.mode  = r_val_mode;
                        shift_ctl.count = r_val_count;
                        shift_data      = r_value;
                    end else begin
                        shift_ctl.step = 1'b1;
                    end
                end
            end
            S_VAL: begin
                if (emit) begin
                    n_out_valid    = 1'b1;
                    n_out.out_byte = shift_byte;
                    n_out.last     = shift_final;
                    shift_ctl.step = !shift_final;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value     <= n_value;
        r_val_mode  <= n_val_mode;
        r_val_count <= n_val_count;
        r_out       <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    `PFE_ASSERT_NEXT(a_known_func_busy, i_clk, i_rst_n, in_fire && func_known, !o_ready)
    `PFE_ASSERT_NOW(a_idle_pending_is_last, i_clk, i_rst_n, (r_state == S_IDLE) && r_out_valid, r_out.last)
    `PFE_ASSERT_NEXT(a_key_to_value, i_clk, i_rst_n, (r_state == S_KEY) && emit && shift_final, r_state == S_VAL)
    `PFE_ASSERT_NEXT(a_unknown_func_idle, i_clk, i_rst_n, in_fire && !func_known, o_ready)

endmodule
